// ===== src/shs_pkg.sv =====
// shs_pkg: widths, the result-stage record and the mixing functions of the
// streaming SuperFastHash unit. No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps
package shs_pkg;

  localparam int BYTE_W = 8;
  localparam int HASH_W = 32;
  localparam int BUF_W  = 24;
  localparam int CNT_W  = 2;

  // Shift amounts of the group mix, tail rules and avalanche
  localparam int SH_GRP_HI   = 11;
  localparam int SH_GRP_WORD = 16;
  localparam int SH_T3_BYTE  = 18;
  localparam int SH_T2_DOWN  = 17;
  localparam int SH_T1_UP    = 10;
  localparam int SH_AV_LAST  = 25;

  // Pending-byte counts that select the tail rule
  localparam logic [CNT_W-1:0] CNT_NONE  = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE   = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO   = 2'd2;
  localparam logic [CNT_W-1:0] CNT_THREE = 2'd3;

  typedef logic [HASH_W-1:0] hash_t;

  // Hash and pending tail of a finished message
  typedef struct packed {
    hash_t             hash;
    logic [BUF_W-1:0]  tail;
    logic [CNT_W-1:0]  cnt;
  } shs_fin_t;

  function automatic hash_t sext8(input logic [BYTE_W-1:0] b);
    return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

  // Mix one group of four bytes (two little-endian words)
  function automatic hash_t mix_group(input hash_t h_in, input logic [15:0] lo,
                                      input logic [15:0] hi);
    hash_t h;
    hash_t t;
    h = h_in + {16'd0, lo};
    t = ({16'd0, hi} << SH_GRP_HI) ^ h;
    h = (h << SH_GRP_WORD) ^ t;
    h = h + (h >> SH_GRP_HI);
    return h;
  endfunction

  // Tail rule, then the first half of the avalanche
  function automatic hash_t finish_a(input shs_fin_t f);
    hash_t h;
    h = f.hash;
    case (f.cnt)
      CNT_THREE: begin
        h = h + {16'd0, f.tail[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(f.tail[23:16]) << SH_T3_BYTE);
        h = h + (h >> 11);
      end
      CNT_TWO: begin
        h = h + {16'd0, f.tail[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> SH_T2_DOWN);
      end
      CNT_ONE: begin
        h = h + sext8(f.tail[7:0]);
        h = h ^ (h << SH_T1_UP);
        h = h + (h >> 1);
      end
      default: ;
    endcase
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    return h;
  endfunction

  // Second half of the avalanche
  function automatic hash_t finish_b(input hash_t h_in);
    hash_t h;
    h = h_in + (h_in >> 17);
    h = h ^ (h << SH_AV_LAST);
    h = h + (h >> 6);
    return h;
  endfunction

endpackage

// ===== src/shs_if.sv =====
// shs_if: valid/ready channel interfaces for message bytes and finished hashes.
// Depends on shs_pkg for the field widths.
`timescale 1ns / 1ps
interface shs_in_if;
  logic                        valid;
  logic                        ready;
  logic [shs_pkg::BYTE_W-1:0]  data_byte;
  logic [shs_pkg::HASH_W-1:0]  message_length;
  logic                        empty_message;
  logic                        last_byte;

  modport source (output valid, data_byte, message_length, empty_message, last_byte,
                  input ready);
  modport sink   (input valid, data_byte, message_length, empty_message, last_byte,
                  output ready);
endinterface

interface shs_out_if;
  logic                        valid;
  logic                        ready;
  logic [shs_pkg::HASH_W-1:0]  hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

// ===== src/superfast_hash_stream_unit.sv =====
// superfast_hash_stream_unit: streaming 32-bit SuperFastHash, one byte per beat.
// Depends on shs_pkg and the channel interfaces in shs_if.sv.
`timescale 1ns / 1ps
// The unit takes one message byte per beat, back to back, with no gaps
// needed between messages. The first beat of a message carries the length
// that seeds the hash; the beat flagged last_byte produces one hash beat,
// and a beat flagged empty_message produces a hash of 0. The per-byte rate
// is one beat per cycle while input ready is high, set by the running-hash
// update (one add, xor and add on the 32-bit hash when a four-byte group
// closes). A finished message passes through the s1_r, s2_r and out_r
// registers: the tail mix and avalanche run in two registered stages. Input
// ready drops only when the first finishing stage is full and cannot move on.
module superfast_hash_stream_unit (
  input  logic        clk,
  input  logic        rst_n,
  shs_in_if.sink      in_ch,
  shs_out_if.source   out_ch
);
  import shs_pkg::*;

  // Running message state
  hash_t             hash_r, hash_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              in_msg_r, in_msg_nxt;

  // Finishing pipeline
  shs_fin_t  s1_r, s1_nxt;
  logic      s1_v_r;
  hash_t     s2_r;
  logic      s2_v_r;
  hash_t     out_r;
  logic      out_v_r;

  logic      s1_ready, s2_ready, out_ready;
  logic      in_fire, push;

  hash_t             h0, h1;
  logic [BUF_W-1:0]  b0, b1;
  logic [CNT_W-1:0]  c0, c1;

  assign out_ready = !out_v_r || out_ch.ready;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_ready  = !s1_v_r || s2_ready;

  assign in_ch.ready = s1_ready;
  assign in_fire     = in_ch.valid && s1_ready;
  assign push        = in_fire && (in_ch.last_byte || in_ch.empty_message);

  // Byte gather and group mix
  always_comb begin
    h0 = in_msg_r ? hash_r : in_ch.message_length;
    b0 = in_msg_r ? buf_r  : '0;
    c0 = in_msg_r ? cnt_r  : CNT_NONE;
    h1 = h0;
    b1 = b0;
    c1 = c0 + CNT_ONE;
    case (c0)
      CNT_THREE: begin
        h1 = mix_group(h0, b0[15:0], {in_ch.data_byte, b0[23:16]});
        b1 = '0;
      end
      CNT_TWO:  b1 = {in_ch.data_byte, b0[15:0]};
      CNT_ONE:  b1 = {b0[23:16], in_ch.data_byte, b0[7:0]};
      default:  b1 = {b0[23:8], in_ch.data_byte};
    endcase
  end

  // Next message state and finishing record
  always_comb begin
    hash_nxt   = hash_r;
    buf_nxt    = buf_r;
    cnt_nxt    = cnt_r;
    in_msg_nxt = in_msg_r;
    s1_nxt     = '{hash: h1, tail: b1, cnt: c1};
    if (in_fire) begin
      if (in_ch.empty_message || in_ch.last_byte) begin
        hash_nxt   = '0;
        buf_nxt    = '0;
        cnt_nxt    = CNT_NONE;
        in_msg_nxt = 1'b0;
      end else begin
        hash_nxt   = h1;
        buf_nxt    = b1;
        cnt_nxt    = c1;
        in_msg_nxt = 1'b1;
      end
    end
    // An all-zero record finishes to a hash of 0
    if (in_ch.empty_message) begin
      s1_nxt = '{hash: '0, tail: '0, cnt: CNT_NONE};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= '0;
      buf_r    <= '0;
      cnt_r    <= CNT_NONE;
      in_msg_r <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hash_r   <= hash_nxt;
      buf_r    <= buf_nxt;
      cnt_r    <= cnt_nxt;
      in_msg_r <= in_msg_nxt;
      if (s1_ready) begin
        s1_v_r <= push;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (out_ready) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Finishing payload registers
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready) begin
      s2_r <= finish_a(s1_r);
    end
    if (out_ready) begin
      out_r <= finish_b(s2_r);
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.hash_value = out_r;

  // A closed message leaves the state idle
  a_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !in_msg_r && hash_r == '0)
    else $error("message state not cleared after last or empty beat");

  // Buffer bytes above the pending count stay zero
  a_buf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_NONE && buf_r == '0) || (cnt_r == CNT_ONE && buf_r[23:8] == '0) ||
    (cnt_r == CNT_TWO && buf_r[23:16] == '0) || cnt_r == CNT_THREE)
    else $error("stale bytes in the byte buffer");

  // Input stalls only behind a full first finishing stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r && s2_v_r && out_v_r)
    else $error("input stalled with room in the finishing pipeline");

  // A finished hash moves on to the output register
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_ready) |=> out_v_r)
    else $error("hash lost between finishing stage and output");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for superfast_hash_stream_unit, byte beats in, hash beats out.
// Depends on shs_pkg and shs_if.sv; a table of directed beats is followed by random messages.
`timescale 1ns / 1ps
module tb;
  import shs_pkg::*;

  // One input beat and one row of the directed table
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [HASH_W-1:0] len;
    logic              is_empty;
    logic              is_last;
  } msg_beat_t;

  typedef struct packed {
    msg_beat_t beat;
    logic      fixed;       // hash typed in below rather than predicted
    hash_t     fixed_hash;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_ITEMS  = 700;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int N_DIRECTED   = 21;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // empty message while idle, every other field at its top value
    '{'{8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, 32'h0000_0000},
    // one-byte messages: zero byte, then a negative byte with the largest length
    '{'{8'h00, 32'd1,         1'b0, 1'b1}, 1'b0, 32'h0},
    '{'{8'h80, 32'hFFFF_FFFF, 1'b0, 1'b1}, 1'b0, 32'h0},
    // two-byte tail
    '{'{8'hFF, 32'd2,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'hFF, 32'd0,         1'b0, 1'b1}, 1'b0, 32'h0},
    // three-byte tail, last byte negative
    '{'{8'h01, 32'd3,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'h02, 32'd3,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'h83, 32'd3,         1'b0, 1'b1}, 1'b0, 32'h0},
    // one full group, zero length as seed
    '{'{8'hFF, 32'd0,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'h00, 32'd0,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'hFF, 32'd0,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'h00, 32'd0,         1'b0, 1'b1}, 1'b0, 32'h0},
    // open message dropped by an empty beat
    '{'{8'h55, 32'd5,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'h00, 32'd0,         1'b1, 1'b0}, 1'b1, 32'h0000_0000},
    // length disagrees with the byte count; mid-message length ignored
    '{'{8'hAA, 32'd7,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'h7F, 32'h1234_5678, 1'b0, 1'b1}, 1'b0, 32'h0},
    // group followed by a one-byte tail
    '{'{8'hFF, 32'd5,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'hFF, 32'd5,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'hFF, 32'd5,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'hFF, 32'd5,         1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'hFF, 32'd5,         1'b0, 1'b1}, 1'b0, 32'h0}
  };

  logic clk;
  logic rst_n;

  shs_in_if  in_ch ();
  shs_out_if out_ch ();

  superfast_hash_stream_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Hash state of the predictor
  hash_t             run_hash;
  logic [BUF_W-1:0]  tail_bytes;
  logic [CNT_W-1:0]  tail_cnt;
  logic              msg_open;

  hash_t pending_hashes[$];
  int    mismatch_count = 0;
  int    beats_sent;
  int    cycle_count = 0;
  int    tx_idle_pct;
  int    rx_idle_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input hash_t got, input hash_t want);
    $display("[%0t] mismatch: %s got %08h want %08h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Advance the predicted hash state by one beat
  function automatic void fold_beat(input msg_beat_t b, output logic has_hash,
                                    output hash_t hash_out);
    hash_t       hsh;
    hash_t       mixed;
    logic [15:0] hi_word;
    has_hash = 1'b0;
    hash_out = '0;
    if (b.is_empty) begin
      run_hash   = '0;
      tail_bytes = '0;
      tail_cnt   = CNT_NONE;
      msg_open   = 1'b0;
      has_hash   = 1'b1;
      return;
    end
    if (!msg_open) begin
      run_hash   = b.len;
      tail_bytes = '0;
      tail_cnt   = CNT_NONE;
      msg_open   = 1'b1;
    end
    // fourth byte closes a group of two little-endian words
    if (tail_cnt == CNT_THREE) begin
      hi_word  = {b.data, tail_bytes[23:16]};
      run_hash = run_hash + {16'd0, tail_bytes[15:0]};
      mixed    = ({16'd0, hi_word} << SH_GRP_HI) ^ run_hash;
      run_hash = (run_hash << SH_GRP_WORD) ^ mixed;
      run_hash = run_hash + (run_hash >> SH_GRP_HI);
      tail_bytes = '0;
      tail_cnt   = CNT_NONE;
    end else begin
      tail_bytes[{tail_cnt, 3'b000} +: BYTE_W] = b.data;
      tail_cnt = tail_cnt + 1'b1;
    end
    if (b.is_last) begin
      hsh = run_hash;
      case (tail_cnt)
        CNT_THREE: begin
          hsh += {16'd0, tail_bytes[15:0]};
          hsh ^= hsh << 16;
          hsh ^= {{24{tail_bytes[23]}}, tail_bytes[23:16]} << SH_T3_BYTE;
          hsh += hsh >> 11;
        end
        CNT_TWO: begin
          hsh += {16'd0, tail_bytes[15:0]};
          hsh ^= hsh << 11;
          hsh += hsh >> SH_T2_DOWN;
        end
        CNT_ONE: begin
          hsh += {{24{tail_bytes[7]}}, tail_bytes[7:0]};
          hsh ^= hsh << SH_T1_UP;
          hsh += hsh >> 1;
        end
        default: ;
      endcase
      // avalanche
      hsh ^= hsh << 3;
      hsh += hsh >> 5;
      hsh ^= hsh << 4;
      hsh += hsh >> 17;
      hsh ^= hsh << SH_AV_LAST;
      hsh += hsh >> 6;
      run_hash   = '0;
      tail_bytes = '0;
      tail_cnt   = CNT_NONE;
      msg_open   = 1'b0;
      has_hash   = 1'b1;
      hash_out   = hsh;
    end
  endfunction

  // Drive one beat, wait for it to be taken, then log the hash it owes
  task automatic send_beat(input msg_beat_t b, input logic fixed, input hash_t fixed_hash);
    logic  has_hash;
    hash_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b.data;
    in_ch.message_length <= b.len;
    in_ch.empty_message  <= b.is_empty;
    in_ch.last_byte      <= b.is_last;
    do @(posedge clk); while (!in_ch.ready);
    fold_beat(b, has_hash, predicted);
    if (has_hash)
      pending_hashes.push_back(fixed ? fixed_hash : predicted);
    beats_sent++;
  endtask

  // Hold the input off until every owed hash is out
  task automatic drain_hashes();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_hashes.size() != 0);
  endtask

  // Idle mix follows the number of beats sent
  task automatic set_idle_phase();
    if (beats_sent < PHASE_ITEMS) begin
      tx_idle_pct = 38;
      rx_idle_pct = 69;
    end else if (beats_sent < 2 * PHASE_ITEMS) begin
      tx_idle_pct = 69;
      rx_idle_pct = 38;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // One random message: mostly well formed, sometimes cut by an empty beat
  task automatic send_random_message();
    msg_beat_t b;
    int        n_bytes;
    int        cut_at;
    logic [HASH_W-1:0] seed_len;
    n_bytes  = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    seed_len = ($urandom_range(7) == 0) ? $urandom : n_bytes;
    cut_at   = ($urandom_range(19) == 0) ? $urandom_range(0, n_bytes - 1) : -1;
    for (int i = 0; i < n_bytes; i++) begin
      b.data     = BYTE_W'($urandom);
      b.len      = (i == 0) ? seed_len : $urandom;
      b.is_empty = (i == cut_at);
      b.is_last  = (i == n_bytes - 1) ? 1'b1 : ($urandom_range(1) == 1);
      if (b.is_empty) begin
        send_beat(b, 1'b1, '0);
        break;
      end
      b.is_last = (i == n_bytes - 1);
      send_beat(b, 1'b0, '0);
    end
  endtask

  // Hash beat checker and output stall
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_hashes.size() == 0)
        report_mismatch("hash beat with none owed", out_ch.hash_value, '0);
      else if (out_ch.hash_value !== pending_hashes[0]) begin
        report_mismatch("hash_value", out_ch.hash_value, pending_hashes[0]);
        void'(pending_hashes.pop_front());
      end else
        void'(pending_hashes.pop_front());
    end
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int        prev_phase_end;
    msg_beat_t b;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.message_length = '0;
    in_ch.empty_message  = 1'b0;
    in_ch.last_byte      = 1'b0;
    beats_sent           = 0;
    run_hash             = '0;
    tail_bytes           = '0;
    tail_cnt             = CNT_NONE;
    msg_open             = 1'b0;
    set_idle_phase();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (DIRECTED_ROWS[i])
      send_beat(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].fixed_hash);
    drain_hashes();

    // random messages with stray empty beats; drain at each idle-phase change
    prev_phase_end = PHASE_ITEMS;
    while (beats_sent < RANDOM_ITEMS + N_DIRECTED) begin
      if (beats_sent >= prev_phase_end) begin
        drain_hashes();
        prev_phase_end += PHASE_ITEMS;
      end
      set_idle_phase();
      if ($urandom_range(99) < 6) begin
        b.data     = BYTE_W'($urandom);
        b.len      = $urandom;
        b.is_empty = 1'b1;
        b.is_last  = 1'($urandom_range(1));
        send_beat(b, 1'b1, '0);
      end else
        send_random_message();
    end

    drain_hashes();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_hashes.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
